// ----- rtl/pipff_pkg.sv -----
package pipff_pkg;

  typedef logic [1:0] seen_t;

  localparam seen_t SEEN_NONE = 2'd0;
  localparam seen_t SEEN_ONE  = 2'd1;
  localparam seen_t SEEN_TWO  = 2'd2;
  localparam seen_t SEEN_MANY = 2'd3;

  localparam int unsigned OUT_FIELDS = 4;
  localparam int unsigned OUT_TDATA_W = 8;

  typedef struct packed {
    logic too_few_vertices;
    logic front_facing;
    logic inside_res;
    logic on_face;
  } result_t;

  typedef struct packed {
    logic gate_a;
    logic dpos_a;
    logic gate_b;
    logic dpos_b;
    logic norm_en;
    logic last;
    logic few;
  } edge_ctl_t;

endpackage

// ----- rtl/pipff_prod_pair.sv -----
module pipff_prod_pair #(
  parameter int DW = 17
) (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic signed [DW-1:0]   a_i,
  input  logic signed [DW-1:0]   b_i,
  input  logic signed [DW-1:0]   c_i,
  input  logic signed [DW-1:0]   d_i,
  output logic signed [2*DW-1:0] ab_o,
  output logic signed [2*DW-1:0] cd_o
);

  logic signed [2*DW-1:0] ab_q, ab_d;
  logic signed [2*DW-1:0] cd_q, cd_d;

  always_comb begin
    ab_d = (2*DW)'(a_i) * (2*DW)'(b_i);
    cd_d = (2*DW)'(c_i) * (2*DW)'(d_i);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ab_q <= ab_d;
      cd_q <= cd_d;
    end
  end

  assign ab_o = ab_q;
  assign cd_o = cd_q;

endmodule

// ----- rtl/point_in_polygon_front_face_core.sv -----
// channel   dir  tdata (low bit up)                                     tlast
// s_axis    in   vertex_x, vertex_y, point_x, point_y, zero pad         last_vertex
// m_axis    out  on_face, inside_res, front_facing, too_few_vertices,   -
//                zero pad to 8 bits
// one vertex beat per cycle while m_axis is not stalled; a result leaves after its last vertex beat
// has passed the input register, the registered multiplier pair and the result register
// reset clears vertex count, parity, front flag and all valid flags
// a stalled m_axis holds the result register and stalls the pipe from the back
module point_in_polygon_front_face_core #(
  parameter int COORD_BITS = 16
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  // vertex_x, vertex_y, point_x, point_y, zero pad
  input  logic [((4*COORD_BITS+7)/8)*8-1:0]     s_axis_tdata_i,
  input  logic                                  s_axis_tlast_i,
  output logic                                  m_axis_tvalid_o,
  input  logic                                  m_axis_tready_i,
  // on_face, inside_res, front_facing, too_few_vertices, zero pad
  output logic [pipff_pkg::OUT_TDATA_W-1:0]     m_axis_tdata_o
);

  import pipff_pkg::*;

  localparam int CB = COORD_BITS;
  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;

  // input beat fields
  logic signed [CB-1:0] in_vx, in_vy, in_px, in_py;
  logic                 in_acc;

  // vertex context, updated on each accepted beat
  seen_t                seen_q, seen_d;
  logic signed [CB-1:0] first_x_q, first_y_q, prev_x_q, prev_y_q, qry_x_q, qry_y_q;

  // stage 1
  logic                 s1_valid_q;
  logic signed [CB-1:0] s1_vx_q, s1_vy_q, s1_px_q, s1_py_q;
  logic signed [CB-1:0] s1_fx_q, s1_fy_q, s1_qx_q, s1_qy_q;
  seen_t                s1_seen_q;
  logic                 s1_last_q;

  // stage 2
  logic                 s2_valid_q;
  edge_ctl_t            s2_ctl_q, s2_ctl_d;
  logic signed [PW-1:0] m1a, m2a, m1b, m2b, n1, n2;

  // accumulated polygon state
  logic                 parity_q, parity_d;
  logic                 front_q, front_d;

  // output
  logic                 out_valid_q;
  result_t              out_res_q, out_res_d;

  logic                 out_free, en2, en1, adv2;

  logic                 cross_a, cross_b;
  logic                 strad_a, left_a, strad_b, left_b;
  logic signed [DW-1:0] a_dyq, a_dxb, a_dxq, a_d;
  logic signed [DW-1:0] b_dyq, b_dxb, b_dxq, b_d;
  logic signed [DW-1:0] nrm_dpx, nrm_dvy, nrm_dpy, nrm_dvx;

  assign in_vx = s_axis_tdata_i[CB-1:0];
  assign in_vy = s_axis_tdata_i[2*CB-1:CB];
  assign in_px = s_axis_tdata_i[3*CB-1:2*CB];
  assign in_py = s_axis_tdata_i[4*CB-1:3*CB];

  assign out_free        = !out_valid_q || m_axis_tready_i;
  assign en2             = !s2_valid_q || out_free;
  assign adv2            = s2_valid_q && out_free;
  assign en1             = !s1_valid_q || en2;
  assign s_axis_tready_o = en1;
  assign in_acc          = s_axis_tvalid_i && en1;

  // vertex count, saturating, cleared after the last vertex
  always_comb begin
    seen_d = seen_q;
    if (in_acc) begin
      if (s_axis_tlast_i) begin
        seen_d = SEEN_NONE;
      end else if (seen_q != SEEN_MANY) begin
        seen_d = seen_q + SEEN_ONE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q     <= SEEN_NONE;
      s1_valid_q <= 1'b0;
    end else begin
      seen_q <= seen_d;
      if (en1) begin
        s1_valid_q <= s_axis_tvalid_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      prev_x_q <= in_vx;
      prev_y_q <= in_vy;
      if (seen_q == SEEN_NONE) begin
        first_x_q <= in_vx;
        first_y_q <= in_vy;
        qry_x_q   <= in_px;
        qry_y_q   <= in_py;
      end
      s1_vx_q   <= in_vx;
      s1_vy_q   <= in_vy;
      s1_px_q   <= prev_x_q;
      s1_py_q   <= prev_y_q;
      s1_fx_q   <= (seen_q == SEEN_NONE) ? in_vx : first_x_q;
      s1_fy_q   <= (seen_q == SEEN_NONE) ? in_vy : first_y_q;
      s1_qx_q   <= (seen_q == SEEN_NONE) ? in_px : qry_x_q;
      s1_qy_q   <= (seen_q == SEEN_NONE) ? in_py : qry_y_q;
      s1_seen_q <= seen_q;
      s1_last_q <= s_axis_tlast_i;
    end
  end

  // edge from new vertex back to previous vertex
  always_comb begin
    strad_a = ((s1_vy_q < s1_qy_q) && (s1_py_q >= s1_qy_q)) ||
              ((s1_py_q < s1_qy_q) && (s1_vy_q >= s1_qy_q));
    left_a  = (s1_vx_q <= s1_qx_q) || (s1_px_q <= s1_qx_q);
    a_dyq   = DW'(s1_qy_q) - DW'(s1_vy_q);
    a_dxb   = DW'(s1_px_q) - DW'(s1_vx_q);
    a_dxq   = DW'(s1_qx_q) - DW'(s1_vx_q);
    a_d     = DW'(s1_py_q) - DW'(s1_vy_q);
  end

  // closing edge from first vertex to new vertex
  always_comb begin
    strad_b = ((s1_fy_q < s1_qy_q) && (s1_vy_q >= s1_qy_q)) ||
              ((s1_vy_q < s1_qy_q) && (s1_fy_q >= s1_qy_q));
    left_b  = (s1_fx_q <= s1_qx_q) || (s1_vx_q <= s1_qx_q);
    b_dyq   = DW'(s1_qy_q) - DW'(s1_fy_q);
    b_dxb   = DW'(s1_vx_q) - DW'(s1_fx_q);
    b_dxq   = DW'(s1_qx_q) - DW'(s1_fx_q);
    b_d     = DW'(s1_vy_q) - DW'(s1_fy_q);
  end

  // normal z of the first three vertices
  always_comb begin
    nrm_dpx = DW'(s1_px_q) - DW'(s1_fx_q);
    nrm_dvy = DW'(s1_vy_q) - DW'(s1_fy_q);
    nrm_dpy = DW'(s1_py_q) - DW'(s1_fy_q);
    nrm_dvx = DW'(s1_vx_q) - DW'(s1_fx_q);
  end

  always_comb begin
    s2_ctl_d.gate_a  = strad_a && left_a && (s1_seen_q != SEEN_NONE);
    s2_ctl_d.dpos_a  = (a_d > 0);
    s2_ctl_d.gate_b  = strad_b && left_b && s1_last_q;
    s2_ctl_d.dpos_b  = (b_d > 0);
    s2_ctl_d.norm_en = (s1_seen_q == SEEN_TWO);
    s2_ctl_d.last    = s1_last_q;
    s2_ctl_d.few     = (s1_seen_q == SEEN_NONE) || (s1_seen_q == SEEN_ONE);
  end

  pipff_prod_pair #(.DW(DW)) u_mul_a (
    .clk_i (clk_i),
    .en_i  (en2),
    .a_i   (a_dyq),
    .b_i   (a_dxb),
    .c_i   (a_dxq),
    .d_i   (a_d),
    .ab_o  (m1a),
    .cd_o  (m2a)
  );

  pipff_prod_pair #(.DW(DW)) u_mul_b (
    .clk_i (clk_i),
    .en_i  (en2),
    .a_i   (b_dyq),
    .b_i   (b_dxb),
    .c_i   (b_dxq),
    .d_i   (b_d),
    .ab_o  (m1b),
    .cd_o  (m2b)
  );

  pipff_prod_pair #(.DW(DW)) u_mul_n (
    .clk_i (clk_i),
    .en_i  (en2),
    .a_i   (nrm_dpx),
    .b_i   (nrm_dvy),
    .c_i   (nrm_dpy),
    .d_i   (nrm_dvx),
    .ab_o  (n1),
    .cd_o  (n2)
  );

  always_ff @(posedge clk_i) begin
    if (en2) begin
      s2_ctl_q <= s2_ctl_d;
    end
  end

  // intersection compare, flipped for a negative denominator
  always_comb begin
    cross_a = s2_ctl_q.gate_a && (s2_ctl_q.dpos_a ? (m1a < m2a) : (m2a < m1a));
    cross_b = s2_ctl_q.gate_b && (s2_ctl_q.dpos_b ? (m1b < m2b) : (m2b < m1b));
    parity_d = parity_q ^ cross_a ^ cross_b;
    front_d  = s2_ctl_q.norm_en ? !(n1 < n2) : front_q;
    out_res_d.inside_res       = parity_d;
    out_res_d.front_facing     = !s2_ctl_q.few && front_d;
    out_res_d.too_few_vertices = s2_ctl_q.few;
    out_res_d.on_face          = !s2_ctl_q.few && front_d && parity_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q  <= 1'b0;
      parity_q    <= 1'b0;
      front_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (en2) begin
        s2_valid_q <= s1_valid_q;
      end
      if (adv2) begin
        if (s2_ctl_q.last) begin
          parity_q <= 1'b0;
          front_q  <= 1'b0;
        end else begin
          parity_q <= parity_d;
          front_q  <= front_d;
        end
      end
      if (out_free) begin
        out_valid_q <= adv2 && s2_ctl_q.last;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv2 && s2_ctl_q.last) begin
      out_res_q <= out_res_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {(OUT_TDATA_W-OUT_FIELDS)'(0), out_res_q};

  a_on_face_needs_all : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (!out_res_q.on_face ||
      (out_res_q.inside_res && out_res_q.front_facing && !out_res_q.too_few_vertices)))
    else $error("on_face without inside and front facing");

  a_few_not_front : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && out_res_q.too_few_vertices |-> !out_res_q.front_facing)
    else $error("too few vertices reported front facing");

  a_last_clears_count : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o && s_axis_tlast_i |=> seen_q == SEEN_NONE)
    else $error("vertex count not cleared after last vertex");

  a_empty_out_ready : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid_o |-> s_axis_tready_o)
    else $error("input stalled with empty output register");

endmodule
